>>> sv/nvs_pkg.sv
// Shared constants for the normalized vector store.
// Holds status codes and fixed-point widths; no dependencies.
package nvs_pkg;

    localparam int SUM_BITS  = 38;   // Q8.30 sum of squares
    localparam int ROOT_BITS = 19;   // integer square root of a 38-bit word
    localparam int RECIP_BITS = 18;  // reciprocal root width
    localparam int SHIFT_BITS = 5;   // normalizing shift count, at most 18

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DIM_ERR  = 3'd1,
        ST_ZERO     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

endpackage

>>> sv/nvs_rsqrt.sv
// Iterative reciprocal square root of the sum of squares.
// Normalizes by pairs of bits, takes the root bit by bit, then divides; uses nvs_pkg.
module nvs_rsqrt
    import nvs_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [SUM_BITS-1:0]     sum,
    output logic                    done,
    output logic [RECIP_BITS-1:0]   recip,
    output logic [SHIFT_BITS-1:0]   shift
);

    typedef enum logic [2:0] {R_IDLE, R_NORM, R_SQRT, R_DIV, R_DONE} rstate_t;

    rstate_t                state_reg;
    logic [SUM_BITS-1:0]    t_reg;
    logic [23:0]            rem_reg;
    logic [ROOT_BITS-1:0]   root_reg;
    logic [ROOT_BITS-1:0]   drem_reg;
    logic [ROOT_BITS-1:0]   q_reg;
    logic [5:0]             cnt_reg;
    logic [SHIFT_BITS-1:0]  e_reg;

    logic [23:0]            rem_sh;
    logic [23:0]            trial;
    logic [ROOT_BITS:0]     drem_sh;

    assign rem_sh  = {rem_reg[21:0], t_reg[SUM_BITS-1 -: 2]};
    assign trial   = {3'b000, root_reg, 2'b01};
    assign drem_sh = {drem_reg, (cnt_reg == 6'd36)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done      <= 1'b0;
        end else begin
            done <= 1'b0;
            case (state_reg)
                R_IDLE: begin
                    if (start) begin
                        t_reg     <= sum;
                        e_reg     <= '0;
                        state_reg <= R_NORM;
                    end
                end
                R_NORM: begin
                    if (t_reg[SUM_BITS-1 -: 2] == 2'b00) begin
                        t_reg <= {t_reg[SUM_BITS-3:0], 2'b00};
                        e_reg <= e_reg + 1'b1;
                    end else begin
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        cnt_reg   <= 6'(ROOT_BITS - 1);
                        state_reg <= R_SQRT;
                    end
                end
                R_SQRT: begin
                    t_reg <= {t_reg[SUM_BITS-3:0], 2'b00};
                    if (rem_sh >= trial) begin
                        rem_reg  <= rem_sh - trial;
                        root_reg <= {root_reg[ROOT_BITS-2:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[ROOT_BITS-2:0], 1'b0};
                    end
                    if (cnt_reg == 6'd0) begin
                        drem_reg  <= '0;
                        q_reg     <= '0;
                        cnt_reg   <= 6'd36;
                        state_reg <= R_DIV;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                R_DIV: begin
                    // Restoring division of 2^36 by the root, one quotient bit a cycle.
                    if (drem_sh >= {1'b0, root_reg}) begin
                        drem_reg <= ROOT_BITS'(drem_sh - {1'b0, root_reg});
                        q_reg    <= {q_reg[ROOT_BITS-2:0], 1'b1};
                    end else begin
                        drem_reg <= drem_sh[ROOT_BITS-1:0];
                        q_reg    <= {q_reg[ROOT_BITS-2:0], 1'b0};
                    end
                    if (cnt_reg == 6'd0) begin
                        state_reg <= R_DONE;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                R_DONE: begin
                    done      <= 1'b1;
                    state_reg <= R_IDLE;
                end
                default: state_reg <= R_IDLE;
            endcase
        end
    end

    // The quotient reaches 2^18 only for the smallest root; clamp it.
    assign recip = q_reg[ROOT_BITS-1] ? {RECIP_BITS{1'b1}} : q_reg[RECIP_BITS-1:0];
    assign shift = e_reg;

endmodule

>>> sv/normalized_vector_store_core.sv
// Top level of the normalized vector store: element intake, normalization, store and readback.
// Depends on nvs_pkg and nvs_rsqrt.
//
// Channel   Dir  Handshake          Contents
// s_*       in   tvalid/tready      tdata: element_value[15:0], vector_index[25:16];
//                                   tuser: mode; tlast: last_element
// m_*       out  tvalid/tready      tdata: out_value[15:0], out_position[21:16],
//                                   stored_count[32:22]; tuser: status; tlast: out_last
// cfg_*     in   cfg_valid/ready    cfg_data: dimension
//
// An element that is not last passes through the accumulate state. A last element adds
// the check, up to 18 normalizing shifts, 19 root steps and 37 divide steps in the
// reciprocal root unit, then read, multiply and write states per element through the one
// multiplier that scales it. Reads use address and output states for the registered store.
// Reset (synchronous, active low) empties the store and sets the dimension to 16.
// A stalled result port holds the sequencer; the input is not ready while it works.
module normalized_vector_store_core
    import nvs_pkg::*;
#(
    parameter int MAX_DIM     = 64,
    parameter int MAX_VECTORS = 1024
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // element_value[15:0], vector_index[25:16], zero fill
    input  logic        s_tuser,   // mode
    input  logic        s_tlast,   // last_element
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_value[15:0], out_position[21:16], stored_count[32:22]
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast,   // out_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // dimension
);

    localparam int PW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int PCW  = $clog2(MAX_DIM + 2);
    localparam int VIW  = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int CNTW = $clog2(MAX_VECTORS + 1);
    localparam int DEPTH = MAX_VECTORS * (1 << PW);

    typedef enum logic [3:0] {
        S_IDLE, S_ACC, S_CHECK, S_RSQ, S_SC_RD, S_SC_MUL, S_SC_WR,
        S_EMIT, S_RD_ADDR, S_RD_OUT
    } state_t;

    state_t                 state_reg;
    logic [6:0]             dim_reg;
    logic [PCW-1:0]         pend_cnt_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [CNTW-1:0]        count_reg;
    logic [16:0]            mag_reg;
    logic                   add_en_reg;
    logic                   last_reg;
    logic [PW-1:0]          p_reg;
    logic [VIW-1:0]         idx_reg;
    logic [34:0]            prod_reg;
    logic                   neg_reg;
    status_t                st_reg;

    logic                   m_valid_reg;
    logic [15:0]            o_value_reg;
    logic [5:0]             o_pos_reg;
    logic                   o_last_reg;
    status_t                o_st_reg;
    logic [10:0]            o_count_reg;

    // Element buffer and vector store.
    logic [15:0]            pend_mem [MAX_DIM];
    logic [15:0]            buf_q;
    logic [15:0]            vmem [DEPTH];
    logic [15:0]            vmem_q;

    logic                   rsq_start;
    logic                   rsq_done;
    logic [RECIP_BITS-1:0]  rsq_recip;
    logic [SHIFT_BITS-1:0]  rsq_shift;

    logic [15:0]            x_in;
    logic [9:0]             idx_in;
    logic [16:0]            mag_in;
    logic [16:0]            mag_buf;
    logic                   out_free;
    logic                   emit_go;
    logic                   dim_bad;
    logic                   s_acc;
    logic                   cfg_acc;
    logic                   buf_we;
    logic                   p_last;
    logic [53:0]            scaled;
    logic [53:0]            rounded;
    logic [32:0]            ym;
    logic [15:0]            y;

    assign x_in    = s_tdata[15:0];
    assign idx_in  = s_tdata[25:16];
    assign mag_in  = x_in[15] ? (17'd0 - {1'b1, x_in}) : {1'b0, x_in};
    assign mag_buf = buf_q[15] ? (17'd0 - {1'b1, buf_q}) : {1'b0, buf_q};

    assign cfg_ready = (state_reg == S_IDLE);
    assign cfg_acc   = cfg_valid && cfg_ready;
    // Configuration wins a tie with an input item in the idle state.
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign s_acc     = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    // A new result is loaded into the output register this cycle.
    assign emit_go   = ((state_reg == S_EMIT) || (state_reg == S_RD_OUT)) && out_free;
    assign dim_bad   = (dim_reg == 7'd0) || (32'(dim_reg) > MAX_DIM);
    assign p_last    = (32'(p_reg) + 32'd1 == 32'(dim_reg));
    assign buf_we    = s_acc && !s_tuser && (32'(pend_cnt_reg) < MAX_DIM);
    assign rsq_start = (state_reg == S_CHECK) && !dim_bad
                       && (32'(pend_cnt_reg) == 32'(dim_reg)) && (sum_reg != '0)
                       && (32'(count_reg) < MAX_VECTORS);

    // Scale by the reciprocal root, undo the normalizing shift, round and saturate.
    assign scaled  = {19'd0, prod_reg} << rsq_shift;
    assign rounded = scaled + (54'd1 << 20);
    assign ym      = rounded[53:21];
    always_comb begin
        if (neg_reg) begin
            y = (ym > 33'd32768) ? 16'h8000 : (~ym[15:0] + 16'd1);
        end else begin
            y = (ym > 33'd32767) ? 16'h7FFF : ym[15:0];
        end
    end

    nvs_rsqrt u_rsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rsq_start),
        .sum     (sum_reg),
        .done    (rsq_done),
        .recip   (rsq_recip),
        .shift   (rsq_shift)
    );

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            pend_mem[pend_cnt_reg[PW-1:0]] <= x_in;
        end
        buf_q <= pend_mem[p_reg];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_SC_WR) begin
            vmem[{count_reg[VIW-1:0], p_reg}] <= y;
        end
        vmem_q <= vmem[{idx_reg, p_reg}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            dim_reg      <= 7'd16;
            pend_cnt_reg <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (cfg_acc) begin
                        // A new dimension starts an empty store.
                        dim_reg      <= cfg_data;
                        pend_cnt_reg <= '0;
                        sum_reg      <= '0;
                        count_reg    <= '0;
                    end else if (s_acc && !s_tuser) begin
                        mag_reg  <= mag_in;
                        last_reg <= s_tlast;
                        if (32'(pend_cnt_reg) < MAX_DIM) begin
                            add_en_reg   <= 1'b1;
                            pend_cnt_reg <= pend_cnt_reg + 1'b1;
                        end else begin
                            add_en_reg   <= 1'b0;
                            pend_cnt_reg <= PCW'(MAX_DIM + 1);
                        end
                        state_reg <= S_ACC;
                    end else if (s_acc) begin
                        if (dim_bad || ({1'b0, idx_in} >= 11'(count_reg))) begin
                            st_reg    <= ST_RANGE;
                            state_reg <= S_EMIT;
                        end else begin
                            idx_reg   <= VIW'(idx_in);
                            p_reg     <= '0;
                            state_reg <= S_RD_ADDR;
                        end
                    end
                end
                S_ACC: begin
                    if (add_en_reg) begin
                        sum_reg <= sum_reg + SUM_BITS'(mag_reg * mag_reg);
                    end
                    state_reg <= last_reg ? S_CHECK : S_IDLE;
                end
                S_CHECK: begin
                    // The pending vector is consumed whatever the outcome.
                    pend_cnt_reg <= '0;
                    sum_reg      <= '0;
                    if (dim_bad || (32'(pend_cnt_reg) != 32'(dim_reg))) begin
                        st_reg    <= ST_DIM_ERR;
                        state_reg <= S_EMIT;
                    end else if (sum_reg == '0) begin
                        st_reg    <= ST_ZERO;
                        state_reg <= S_EMIT;
                    end else if (32'(count_reg) >= MAX_VECTORS) begin
                        st_reg    <= ST_FULL;
                        state_reg <= S_EMIT;
                    end else begin
                        state_reg <= S_RSQ;
                    end
                end
                S_RSQ: begin
                    if (rsq_done) begin
                        p_reg     <= '0;
                        state_reg <= S_SC_RD;
                    end
                end
                S_SC_RD: begin
                    state_reg <= S_SC_MUL;
                end
                S_SC_MUL: begin
                    prod_reg  <= mag_buf * rsq_recip;
                    neg_reg   <= buf_q[15];
                    state_reg <= S_SC_WR;
                end
                S_SC_WR: begin
                    if (p_last) begin
                        count_reg <= count_reg + 1'b1;
                        st_reg    <= ST_OK;
                        state_reg <= S_EMIT;
                    end else begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= S_SC_RD;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        o_value_reg <= '0;
                        o_pos_reg   <= '0;
                        o_last_reg  <= 1'b1;
                        o_st_reg    <= st_reg;
                        o_count_reg <= 11'(count_reg);
                        state_reg   <= S_IDLE;
                    end
                end
                S_RD_ADDR: begin
                    state_reg <= S_RD_OUT;
                end
                S_RD_OUT: begin
                    if (out_free) begin
                        o_value_reg <= vmem_q;
                        o_pos_reg   <= 6'(p_reg);
                        o_last_reg  <= p_last;
                        o_st_reg    <= ST_OK;
                        o_count_reg <= 11'(count_reg);
                        if (p_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            p_reg     <= p_reg + 1'b1;
                            state_reg <= S_RD_ADDR;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, o_count_reg, o_pos_reg, o_value_reg};
    assign m_tuser  = o_st_reg;
    assign m_tlast  = o_last_reg;

    // The store never holds more vectors than it has room for.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= MAX_VECTORS)
        else $error("vector count above store size");

    // The pending count saturates one past the largest dimension.
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pend_cnt_reg) <= MAX_DIM + 1)
        else $error("pending count out of range");

    // The root unit finishes only while the sequencer waits for it.
    a_rsq_done: assert property (@(posedge aclk) disable iff (!aresetn)
        rsq_done |-> (state_reg == S_RSQ))
        else $error("reciprocal root finished outside its wait state");

    // A configuration write empties the store.
    a_cfg_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_acc |=> (count_reg == '0) && (pend_cnt_reg == '0))
        else $error("store not emptied after configuration write");

endmodule

>>> tb/nvs_checker.sv
// Checker for the normalized vector store: watches the input, configuration and result
// channels, predicts every result, and compares each one field by field.
// Depends on nvs_pkg for the status codes.
module nvs_checker
    import nvs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    output int          fail_count,
    output int          results_due
);

    localparam int DIM_LIMIT   = 64;
    localparam int STORE_LIMIT = 1024;
    localparam logic [37:0] SUM_MASK = {38{1'b1}};

    typedef struct packed {
        logic [15:0] value;
        logic [5:0]  pos;
        logic        at_end;
        status_t     st;
        logic [10:0] count;
    } nvs_result_t;

    nvs_result_t  expected_results[$];
    logic [6:0]   dim_reg;
    logic [15:0]  element_buf [0:DIM_LIMIT-1];
    int unsigned  element_count;
    logic [37:0]  sum_sq;
    logic [15:0]  unit_store [0:STORE_LIMIT*DIM_LIMIT-1];
    int unsigned  vec_count;

    initial begin
        fail_count  = 0;
        results_due = 0;
    end

    task automatic report_mismatch(input string what);
        if (fail_count < 20)
            $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    // Appends one predicted result at the tail of the queue.
    task automatic queue_result(input nvs_result_t res);
        expected_results.insert(expected_results.size(), res);
    endtask

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic nvs_result_t status_only(input status_t st);
        nvs_result_t r;
        r.value  = '0;
        r.pos    = '0;
        r.at_end = 1'b1;
        r.st     = st;
        r.count  = vec_count[10:0];
        return r;
    endfunction

    // Closes the pending vector: checks it, then scales it to unit length and stores it.
    function automatic status_t close_vector();
        logic [63:0] t;
        logic [63:0] root;
        logic [63:0] recip;
        logic [63:0] mag;
        logic [63:0] ym;
        int unsigned e;
        logic signed [15:0] x;
        logic [15:0] y;
        if (dim_reg == 0 || dim_reg > DIM_LIMIT || element_count != dim_reg)
            return ST_DIM_ERR;
        if (sum_sq == 0)
            return ST_ZERO;
        if (vec_count >= STORE_LIMIT)
            return ST_FULL;
        t = {26'd0, sum_sq};
        e = 0;
        while (t < (64'd1 << 36)) begin
            t = t << 2;
            e++;
        end
        root  = int_sqrt(t);
        recip = (64'd1 << 36) / root;
        if (recip > 64'd262143)
            recip = 64'd262143;
        for (int p = 0; p < element_count; p++) begin
            x   = element_buf[p];
            mag = (x < 0) ? 64'(-32'(x)) : 64'(x);
            ym  = (((mag * recip) << e) + (64'd1 << 20)) >> 21;
            if (x < 0)
                y = (ym > 32768) ? 16'h8000 : 16'(-ym);
            else
                y = (ym > 32767) ? 16'h7fff : ym[15:0];
            unit_store[vec_count * DIM_LIMIT + p] = y;
        end
        vec_count++;
        return ST_OK;
    endfunction

    always @(posedge aclk) begin
        logic signed [15:0] x;
        logic [63:0]        mag;
        logic [9:0]         idx;
        nvs_result_t        r;
        nvs_result_t        got;
        if (!aresetn) begin
            dim_reg       = 7'd16;
            element_count = 0;
            sum_sq        = '0;
            vec_count     = 0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                dim_reg       = cfg_data;
                element_count = 0;
                sum_sq        = '0;
                vec_count     = 0;
            end
            if (s_tvalid && s_tready) begin
                if (!s_tuser) begin
                    x = s_tdata[15:0];
                    if (element_count < DIM_LIMIT) begin
                        mag = (x < 0) ? 64'(-32'(x)) : 64'(x);
                        element_buf[element_count] = s_tdata[15:0];
                        sum_sq = (sum_sq + 38'(mag * mag)) & SUM_MASK;
                        element_count++;
                    end else begin
                        element_count = DIM_LIMIT + 1;
                    end
                    if (s_tlast) begin
                        r = status_only(close_vector());
                        r.count = vec_count[10:0];
                        element_count = 0;
                        sum_sq = '0;
                        queue_result(r);
                    end
                end else begin
                    idx = s_tdata[25:16];
                    if (idx >= vec_count || dim_reg == 0 || dim_reg > DIM_LIMIT) begin
                        queue_result(status_only(ST_RANGE));
                    end else begin
                        for (int p = 0; p < dim_reg; p++) begin
                            r.value  = unit_store[idx * DIM_LIMIT + p];
                            r.pos    = p[5:0];
                            r.at_end = (p + 1 == dim_reg);
                            r.st     = ST_OK;
                            r.count  = vec_count[10:0];
                            queue_result(r);
                        end
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                got.value  = m_tdata[15:0];
                got.pos    = m_tdata[21:16];
                got.count  = m_tdata[32:22];
                got.st     = status_t'(m_tuser);
                got.at_end = m_tlast;
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    r = expected_results.pop_front();
                    if (got.value !== r.value)
                        report_mismatch($sformatf("value %h, expected %h", got.value, r.value));
                    if (got.pos !== r.pos)
                        report_mismatch($sformatf("position %0d, expected %0d", got.pos, r.pos));
                    if (got.at_end !== r.at_end)
                        report_mismatch($sformatf("last %b, expected %b", got.at_end, r.at_end));
                    if (got.st !== r.st)
                        report_mismatch($sformatf("status %0d, expected %0d", got.st, r.st));
                    if (got.count !== r.count)
                        report_mismatch($sformatf("count %0d, expected %0d", got.count, r.count));
                end
            end
        end
        results_due = expected_results.size();
    end

endmodule

>>> tb/tb.sv
// Top of the normalized vector store testbench: clock, reset, stimulus and verdict.
// Depends on normalized_vector_store_core and nvs_checker.
module tb;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // element_value[15:0], vector_index[25:16], zero fill
    logic        s_tuser;    // mode
    logic        s_tlast;    // last_element
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // out_value[15:0], out_position[21:16], stored_count[32:22]
    logic [2:0]  m_tuser;    // status
    logic        m_tlast;    // out_last
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;   // dimension

    int fail_count;
    int results_due;
    int gap_pct;       // chance in percent that a side idles in a given cycle
    int hold_cycles;   // cycles the receiver still has to hold off
    int dim_now;       // dimension the stimulus is currently building vectors for

    normalized_vector_store_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    nvs_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .results_due(results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // A run that has not finished by now is hung; the slowest correct run is far shorter.
    initial begin
        #20000000;
        $display("tb: FAIL");
        $finish;
    end

    // The receiver idles at random, or holds off completely while hold_cycles runs down.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= gap_pct);
            end
        end
    end

    // Offers one item and returns at the falling edge after its transfer. The valid is
    // left high, so the caller either sends the next item at once or lowers it.
    task automatic send_item(input logic rd, input logic [15:0] val, input logic fin,
                             input logic [9:0] idx);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rd;
        s_tlast  <= fin;
        s_tdata  <= {6'd0, idx, val};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Kinds of element content: full random, small magnitudes, or all zero.
    localparam int FILL_RANDOM = 0;
    localparam int FILL_SMALL  = 1;
    localparam int FILL_ZERO   = 2;

    task automatic send_vector(input int len, input int fill);
        logic [15:0] v;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_SMALL: v = 16'($signed($urandom_range(14)) - 7);
                FILL_ZERO:  v = '0;
                default:    v = 16'($urandom);
            endcase
            send_item(1'b0, v, i == len - 1, 10'($urandom));
        end
    endtask

    task automatic send_read(input logic [9:0] idx);
        send_item(1'b1, 16'($urandom), $urandom_range(1), idx);
    endtask

    // Stops offering items and waits until every predicted result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (results_due != 0)
            @(negedge aclk);
    endtask

    // The dimension is only written while the block is idle. After the predicted results
    // have drained, the block is also given time to finish a normalization pass before
    // the write.
    task automatic write_dimension(input logic [6:0] d);
        drain_results();
        repeat (300) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        dim_now = d;
    endtask

    // Mostly well-formed vectors with random content and reads of stored vectors;
    // the rest are zero vectors, wrong lengths, wide reads and stray elements.
    task automatic random_traffic(input int n_items);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                send_vector(dim_now, ($urandom_range(7) == 0) ? FILL_SMALL : FILL_RANDOM);
                sent += dim_now;
            end else if (pick < 75) begin
                send_read(10'($urandom_range(7)));
                sent++;
            end else if (pick < 80) begin
                send_read(10'($urandom));
                sent++;
            end else if (pick < 86) begin
                send_vector(dim_now, FILL_ZERO);
                sent += dim_now;
            end else if (pick < 94) begin
                len = (dim_now > 1 && $urandom_range(1)) ? dim_now - 1 : dim_now + 1;
                send_vector(len, FILL_RANDOM);
                sent += len;
            end else begin
                send_item(1'b0, 16'($urandom), 1'b0, 10'($urandom));
                sent++;
            end
        end
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        s_tlast     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        gap_pct     = 33;
        hold_cycles = 0;
        dim_now     = 16;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The dimension after reset is 16; build and read back under it.
        send_read(10'd0);
        send_vector(16, FILL_RANDOM);
        send_read(10'd0);

        // Directed cases at a dimension of three: field extremes, a zero vector,
        // short and long vectors, the smallest nonzero vector, reads past the count.
        write_dimension(7'd3);
        send_read(10'd0);
        send_item(1'b0, 16'h8000, 1'b0, 10'h3ff);
        send_item(1'b0, 16'h7fff, 1'b0, 10'h000);
        send_item(1'b0, 16'h0001, 1'b1, 10'h2aa);
        send_vector(3, FILL_ZERO);
        send_vector(2, FILL_RANDOM);
        send_vector(4, FILL_RANDOM);
        send_item(1'b0, 16'h0000, 1'b0, 10'h155);
        send_item(1'b0, 16'h0001, 1'b0, 10'h000);
        send_item(1'b0, 16'h0000, 1'b1, 10'h000);
        send_item(1'b0, 16'h8000, 1'b0, 10'h000);
        send_item(1'b0, 16'h8000, 1'b0, 10'h000);
        send_item(1'b0, 16'hffff, 1'b1, 10'h000);
        send_read(10'd0);
        send_read(10'd2);
        send_read(10'd3);
        send_read(10'h3ff);

        // Largest dimension, and a vector that runs past the buffer and is dropped.
        write_dimension(7'd64);
        gap_pct = 0;
        send_vector(64, FILL_RANDOM);
        send_vector(66, FILL_RANDOM);
        gap_pct = 33;
        drain_results();
        // The receiver holds off while reads keep coming, so the block backs up.
        hold_cycles = 600;
        for (int i = 0; i < 4; i++)
            send_read(10'($urandom_range(1)));
        drain_results();

        // Dimension one: a run of single-element vectors, then reads across the store.
        write_dimension(7'd1);
        gap_pct = 0;
        for (int i = 0; i < 20; i++)
            send_vector(1, (i % 7 == 5) ? FILL_ZERO : FILL_RANDOM);
        gap_pct = 33;
        send_read(10'h3ff);
        for (int i = 0; i < 4; i++)
            send_read(10'($urandom_range(24)));

        // Dimensions the block cannot hold: every vector is the wrong length.
        write_dimension(7'd0);
        send_vector(1, FILL_RANDOM);
        send_read(10'd0);
        write_dimension(7'd127);
        send_vector(2, FILL_RANDOM);
        send_read(10'd0);
        write_dimension(7'd65);
        send_vector(3, FILL_RANDOM);
        send_read(10'd0);

        // Random traffic over two small dimensions.
        write_dimension(7'($urandom_range(2, 6)));
        random_traffic(25);
        write_dimension(7'($urandom_range(7, 12)));
        random_traffic(25);

        drain_results();
        repeat (300) @(posedge aclk);
        if (fail_count == 0 && results_due == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
